FILE: sv/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for epoch_seconds_to_calendar
// Holds the sequencer state type, the fixed divisors and the month table.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Field widths of the input and result words.
    localparam int EpochWidth   = 32;
    localparam int YearWidth    = 12;
    localparam int MonthWidth   = 4;
    localparam int MdayWidth    = 5;
    localparam int HourWidth    = 5;
    localparam int MinuteWidth  = 6;
    localparam int SecondWidth  = 6;

    // Internal widths.
    localparam int QuoWidth     = 16;  // day count below 2^16
    localparam int SodWidth     = 17;  // seconds of day below 86400
    localparam int CycWidth     = 6;   // four-year cycles below 33
    localparam int CntWidth     = 4;

    // Fixed divisors and limits.
    localparam logic [EpochWidth-1:0] SecondsPerDay  = 32'd86400;
    localparam logic [EpochWidth-1:0] DaysPerCycle   = 32'd1461;
    localparam logic [EpochWidth-1:0] SecondsPerHour = 32'd3600;
    localparam logic [EpochWidth-1:0] SecondsPerMin  = 32'd60;
    localparam logic [EpochWidth-1:0] LimitSeconds   = 32'd4102444800;
    localparam logic [YearWidth-1:0]  BaseYear       = 12'd1970;

    // Bit steps of each restoring division, highest shift first.
    localparam logic [CntWidth-1:0] DayTopBit  = 4'd15;
    localparam logic [CntWidth-1:0] CycTopBit  = 4'd5;
    localparam logic [CntWidth-1:0] HourTopBit = 4'd4;
    localparam logic [CntWidth-1:0] MinTopBit  = 4'd5;

    // Index of the leap year in each four-year group, and the last year and month indices.
    localparam logic [1:0]          LeapYearIdx = 2'd2;
    localparam logic [CntWidth-1:0] LastYearIdx = 4'd3;
    localparam logic [CntWidth-1:0] LastMonIdx  = 4'd11;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAY,
        ST_CYC,
        ST_YEAR,
        ST_MON,
        ST_HOUR,
        ST_MIN,
        ST_DONE
    } esc_state_t;

    // Length in days of a year of the cycle.
    function automatic logic [EpochWidth-1:0] year_len(input logic [1:0] yidx);
        year_len = (yidx == LeapYearIdx) ? 32'd366 : 32'd365;
    endfunction

    // Length in days of a month, 0 is January.
    function automatic logic [EpochWidth-1:0] month_len(input logic [CntWidth-1:0] mon,
                                                        input logic leap);
        logic [EpochWidth-1:0] len;
        case (mon)
            4'd1:    len = leap ? 32'd29 : 32'd28;
            4'd3:    len = 32'd30;
            4'd5:    len = 32'd30;
            4'd8:    len = 32'd30;
            4'd10:   len = 32'd30;
            default: len = 32'd31;
        endcase
        month_len = len;
    endfunction

endpackage

FILE: sv/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to calendar date and time
// Converts a whole second count into year, month, day, hour, minute, second.
// ----------------------------------------------------------------------------
// One word is worked at a time by a single shared compare-and-subtract unit
// under a small sequencer. An accepted word goes through the day split, the
// four-year cycle split, the year walk, the month walk, the hour split and the
// minute split, and the result is then handed to the output register; the
// next word is taken only after that hand-off, which waits while the output
// register holds a result not yet taken. A word at or after 2100-01-01
// 00:00:00 skips the work and goes straight to the hand-off with out_of_range
// set and all other fields zero. The output register lets the result wait
// while s_ready returns; the dates are valid from 1970 through 2099, where
// every fourth year is a leap year.
module epoch_seconds_to_calendar (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [esc_pkg::EpochWidth-1:0]    s_epoch_seconds,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [esc_pkg::YearWidth-1:0]     m_year,
    output logic [esc_pkg::MonthWidth-1:0]    m_month,
    output logic [esc_pkg::MdayWidth-1:0]     m_day_of_month,
    output logic [esc_pkg::HourWidth-1:0]     m_hour,
    output logic [esc_pkg::MinuteWidth-1:0]   m_minute,
    output logic [esc_pkg::SecondWidth-1:0]   m_second,
    output logic                              m_out_of_range
);
    import esc_pkg::*;

    esc_state_t state_reg, state_next;

    logic [EpochWidth-1:0]  rem_reg, rem_next;
    logic [QuoWidth-1:0]    quo_reg, quo_next;
    logic [CntWidth-1:0]    cnt_reg, cnt_next;
    logic [SodWidth-1:0]    sod_reg, sod_next;
    logic [CycWidth-1:0]    cyc_reg, cyc_next;
    logic [1:0]             yidx_reg, yidx_next;
    logic [CntWidth-1:0]    mon_reg, mon_next;
    logic [MdayWidth-1:0]   mday_reg, mday_next;
    logic [HourWidth-1:0]   hour_reg, hour_next;
    logic [MinuteWidth-1:0] min_reg, min_next;
    logic [SecondWidth-1:0] sec_reg, sec_next;
    logic                   oor_reg, oor_next;

    logic                   m_valid_reg, m_valid_next;
    logic [YearWidth-1:0]   m_year_reg, m_year_next;
    logic [MonthWidth-1:0]  m_month_reg, m_month_next;
    logic [MdayWidth-1:0]   m_mday_reg, m_mday_next;
    logic [HourWidth-1:0]   m_hour_reg, m_hour_next;
    logic [MinuteWidth-1:0] m_min_reg, m_min_next;
    logic [SecondWidth-1:0] m_sec_reg, m_sec_next;
    logic                   m_oor_reg, m_oor_next;

    logic [EpochWidth-1:0]  sub_val;
    logic [EpochWidth:0]    diff;
    logic                   ge;
    logic [EpochWidth-1:0]  work_after;
    logic [QuoWidth-1:0]    quo_after;
    logic                   in_oor;
    logic                   out_free;
    logic                   last_step;

    // Subtrahend for the shared unit, chosen by the current phase.
    always_comb begin
        case (state_reg)
            ST_DAY:  sub_val = SecondsPerDay << cnt_reg;
            ST_CYC:  sub_val = DaysPerCycle << cnt_reg;
            ST_YEAR: sub_val = year_len(cnt_reg[1:0]);
            ST_MON:  sub_val = month_len(cnt_reg, yidx_reg == LeapYearIdx);
            ST_HOUR: sub_val = SecondsPerHour << cnt_reg;
            ST_MIN:  sub_val = SecondsPerMin << cnt_reg;
            default: sub_val = '0;
        endcase
    end

    // Shared compare-and-subtract unit.
    assign diff       = {1'b0, rem_reg} - {1'b0, sub_val};
    assign ge         = ~diff[EpochWidth];
    assign work_after = ge ? diff[EpochWidth-1:0] : rem_reg;
    assign quo_after  = {quo_reg[QuoWidth-2:0], ge};
    assign last_step  = (cnt_reg == '0);

    assign in_oor   = (s_epoch_seconds >= LimitSeconds);
    assign out_free = ~m_valid_reg | m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = in_oor ? ST_DONE : ST_DAY;
                end
            end
            ST_DAY: begin
                if (last_step) begin
                    state_next = ST_CYC;
                end
            end
            ST_CYC: begin
                if (last_step) begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (!(ge && cnt_reg < LastYearIdx)) begin
                    state_next = ST_MON;
                end
            end
            ST_MON: begin
                if (!(ge && cnt_reg < LastMonIdx)) begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR: begin
                if (last_step) begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN: begin
                if (last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        sod_next     = sod_reg;
        cyc_next     = cyc_reg;
        yidx_next    = yidx_reg;
        mon_next     = mon_reg;
        mday_next    = mday_reg;
        hour_next    = hour_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        oor_next     = oor_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_year_next  = m_year_reg;
        m_month_next = m_month_reg;
        m_mday_next  = m_mday_reg;
        m_hour_next  = m_hour_reg;
        m_min_next   = m_min_reg;
        m_sec_next   = m_sec_reg;
        m_oor_next   = m_oor_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rem_next = s_epoch_seconds;
                    quo_next = '0;
                    cnt_next = DayTopBit;
                    oor_next = in_oor;
                end
            end
            ST_DAY: begin
                rem_next = work_after;
                quo_next = quo_after;
                cnt_next = cnt_reg - 1'b1;
                if (last_step) begin
                    sod_next = work_after[SodWidth-1:0];
                    rem_next = {{(EpochWidth-QuoWidth){1'b0}}, quo_after};
                    quo_next = '0;
                    cnt_next = CycTopBit;
                end
            end
            ST_CYC: begin
                rem_next = work_after;
                quo_next = quo_after;
                cnt_next = cnt_reg - 1'b1;
                if (last_step) begin
                    cyc_next = quo_after[CycWidth-1:0];
                    cnt_next = '0;
                end
            end
            ST_YEAR: begin
                if (ge && cnt_reg < LastYearIdx) begin
                    rem_next = diff[EpochWidth-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    yidx_next = cnt_reg[1:0];
                    cnt_next  = '0;
                end
            end
            ST_MON: begin
                if (ge && cnt_reg < LastMonIdx) begin
                    rem_next = diff[EpochWidth-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    mon_next  = cnt_reg;
                    mday_next = rem_reg[MdayWidth-1:0] + 1'b1;
                    rem_next  = {{(EpochWidth-SodWidth){1'b0}}, sod_reg};
                    quo_next  = '0;
                    cnt_next  = HourTopBit;
                end
            end
            ST_HOUR: begin
                rem_next = work_after;
                quo_next = quo_after;
                cnt_next = cnt_reg - 1'b1;
                if (last_step) begin
                    hour_next = quo_after[HourWidth-1:0];
                    quo_next  = '0;
                    cnt_next  = MinTopBit;
                end
            end
            ST_MIN: begin
                rem_next = work_after;
                quo_next = quo_after;
                cnt_next = cnt_reg - 1'b1;
                if (last_step) begin
                    min_next = quo_after[MinuteWidth-1:0];
                    sec_next = work_after[SecondWidth-1:0];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_oor_next   = oor_reg;
                    if (oor_reg) begin
                        m_year_next  = '0;
                        m_month_next = '0;
                        m_mday_next  = '0;
                        m_hour_next  = '0;
                        m_min_next   = '0;
                        m_sec_next   = '0;
                    end else begin
                        m_year_next  = BaseYear + {4'b0000, cyc_reg, yidx_reg};
                        m_month_next = mon_reg + 1'b1;
                        m_mday_next  = mday_reg;
                        m_hour_next  = hour_reg;
                        m_min_next   = min_reg;
                        m_sec_next   = sec_reg;
                    end
                end
            end
            default: begin
                oor_next = oor_reg;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = m_valid_reg;
    end

    assign m_year         = m_year_reg;
    assign m_month        = m_month_reg;
    assign m_day_of_month = m_mday_reg;
    assign m_hour         = m_hour_reg;
    assign m_minute       = m_min_reg;
    assign m_second       = m_sec_reg;
    assign m_out_of_range = m_oor_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        sod_reg     <= sod_next;
        cyc_reg     <= cyc_next;
        yidx_reg    <= yidx_next;
        mon_reg     <= mon_next;
        mday_reg    <= mday_next;
        hour_reg    <= hour_next;
        min_reg     <= min_next;
        sec_reg     <= sec_next;
        oor_reg     <= oor_next;
        m_year_reg  <= m_year_next;
        m_month_reg <= m_month_next;
        m_mday_reg  <= m_mday_next;
        m_hour_reg  <= m_hour_next;
        m_min_reg   <= m_min_next;
        m_sec_reg   <= m_sec_next;
        m_oor_reg   <= m_oor_next;
    end

endmodule

FILE: test/calendar_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_checker: watches both channels of epoch_seconds_to_calendar
// Predicts the calendar date of every accepted input word, queues the
// prediction and compares each result word against the oldest one in order.
// ----------------------------------------------------------------------------
module calendar_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [esc_pkg::EpochWidth-1:0]    s_epoch_seconds,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [esc_pkg::YearWidth-1:0]     m_year,
    input  logic [esc_pkg::MonthWidth-1:0]    m_month,
    input  logic [esc_pkg::MdayWidth-1:0]     m_day_of_month,
    input  logic [esc_pkg::HourWidth-1:0]     m_hour,
    input  logic [esc_pkg::MinuteWidth-1:0]   m_minute,
    input  logic [esc_pkg::SecondWidth-1:0]   m_second,
    input  logic                              m_out_of_range,
    output int                                fail_count,
    output int                                dates_pending
);

    localparam int unsigned DaySeconds    = 86400;
    localparam int unsigned HourSeconds   = 3600;
    localparam int unsigned MinuteSeconds = 60;
    localparam int unsigned CycleDays     = 1461;
    localparam int unsigned CycleMonths   = 48;
    localparam int unsigned FirstYear     = 1970;
    localparam int unsigned EndOfRange    = 32'd4102444800;

    typedef struct packed {
        logic [esc_pkg::YearWidth-1:0]   year;
        logic [esc_pkg::MonthWidth-1:0]  month;
        logic [esc_pkg::MdayWidth-1:0]   mday;
        logic [esc_pkg::HourWidth-1:0]   hour;
        logic [esc_pkg::MinuteWidth-1:0] minute;
        logic [esc_pkg::SecondWidth-1:0] second;
        logic                            out_of_range;
    } calendar_t;

    calendar_t expected_dates[$];
    int        results_seen;

    // Days in a month of the four-year cycle; the third year of a cycle is leap.
    function automatic int unsigned cycle_month_days(input int unsigned idx);
        int unsigned cycle_year;
        int unsigned mon;
        cycle_year = idx / 12;
        mon        = idx % 12;
        case (mon)
            1: begin
                return (cycle_year == 2) ? 29 : 28;
            end
            3, 5, 8, 10: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    // Calendar date and time of day for a count of seconds since 1970.
    function automatic calendar_t date_of_epoch(input logic [31:0] secs);
        calendar_t   d;
        int unsigned days;
        int unsigned sod;
        int unsigned cycles;
        int unsigned day_left;
        int unsigned mon;
        int unsigned field;
        d = '0;
        if (secs >= EndOfRange) begin
            d.out_of_range = 1'b1;
            return d;
        end
        days     = secs / DaySeconds;
        sod      = secs % DaySeconds;
        cycles   = days / CycleDays;
        day_left = days % CycleDays;
        mon      = 0;
        while (mon < CycleMonths - 1 && day_left >= cycle_month_days(mon)) begin
            day_left -= cycle_month_days(mon);
            mon++;
        end
        field    = FirstYear + cycles * 4 + mon / 12;
        d.year   = field[esc_pkg::YearWidth-1:0];
        field    = mon % 12 + 1;
        d.month  = field[esc_pkg::MonthWidth-1:0];
        field    = day_left + 1;
        d.mday   = field[esc_pkg::MdayWidth-1:0];
        field    = sod / HourSeconds;
        d.hour   = field[esc_pkg::HourWidth-1:0];
        field    = (sod % HourSeconds) / MinuteSeconds;
        d.minute = field[esc_pkg::MinuteWidth-1:0];
        field    = sod % MinuteSeconds;
        d.second = field[esc_pkg::SecondWidth-1:0];
        return d;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t ns: result word %0d, %s: expected %0d, got %0d",
                 $time, results_seen, what, want, got);
        fail_count++;
    endtask

    // Compare each result word first, then queue the prediction for a new input word.
    always @(posedge aclk) begin
        calendar_t want;
        if (!aresetn) begin
            fail_count    = 0;
            dates_pending = 0;
            results_seen  = 0;
            expected_dates.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("result word with no input waiting", 0, 32'(m_year));
                end else begin
                    want = expected_dates.pop_front();
                    if (m_year !== want.year)
                        report_mismatch("year", 32'(want.year), 32'(m_year));
                    if (m_month !== want.month)
                        report_mismatch("month", 32'(want.month), 32'(m_month));
                    if (m_day_of_month !== want.mday)
                        report_mismatch("day_of_month", 32'(want.mday),
                                        32'(m_day_of_month));
                    if (m_hour !== want.hour)
                        report_mismatch("hour", 32'(want.hour), 32'(m_hour));
                    if (m_minute !== want.minute)
                        report_mismatch("minute", 32'(want.minute), 32'(m_minute));
                    if (m_second !== want.second)
                        report_mismatch("second", 32'(want.second), 32'(m_second));
                    if (m_out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", 32'(want.out_of_range),
                                        32'(m_out_of_range));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                expected_dates.push_back(date_of_epoch(s_epoch_seconds));
            end
            dates_pending = expected_dates.size();
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for epoch_seconds_to_calendar
// Drives directed and random second counts with random gaps on the input and
// random stalls on the output; calendar_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

    localparam int RandomWords   = 1230;
    localparam int QuietTail     = 150;
    localparam int LongHoldAt    = 400;
    localparam int LongHoldLen   = 400;
    localparam int DrainCycles   = 80;
    localparam int LimitNs       = 6000000;
    localparam int unsigned LastInRange = 32'd4102444799;
    localparam int unsigned LastDay     = 47481;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [esc_pkg::EpochWidth-1:0]    s_epoch_seconds;
    logic                              m_valid;
    logic                              m_ready;
    logic [esc_pkg::YearWidth-1:0]     m_year;
    logic [esc_pkg::MonthWidth-1:0]    m_month;
    logic [esc_pkg::MdayWidth-1:0]     m_day_of_month;
    logic [esc_pkg::HourWidth-1:0]     m_hour;
    logic [esc_pkg::MinuteWidth-1:0]   m_minute;
    logic [esc_pkg::SecondWidth-1:0]   m_second;
    logic                              m_out_of_range;

    int fail_count;
    int dates_pending;
    bit quiet_tail;
    bit hold_request;

    epoch_seconds_to_calendar DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day_of_month  (m_day_of_month),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second),
        .m_out_of_range  (m_out_of_range)
    );

    calendar_checker checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day_of_month  (m_day_of_month),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second),
        .m_out_of_range  (m_out_of_range),
        .fail_count      (fail_count),
        .dates_pending   (dates_pending)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one word, with an occasional gap first, and hold it until accepted.
    task automatic send_seconds(input logic [31:0] secs);
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_epoch_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Result side: random stall bursts, one long hold-off, none in the tail.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                m_ready <= 1'b0;
                repeat (LongHoldLen) @(negedge aclk);
                m_ready   <= 1'b1;
                hold_done = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [31:0] directed_words[$];
        logic [31:0] secs;
        int unsigned day;
        int          drain;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_epoch_seconds = '0;
        quiet_tail      = 1'b0;
        hold_request    = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Epoch start, time-of-day edges, leap day, end of a four-year cycle,
        // the last in-range second and the first and last out-of-range words.
        directed_words = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
                           32'd86399, 32'd86400, 32'd2678399, 32'd2678400,
                           32'd31535999, 32'd31536000, 32'd68169599, 32'd68169600,
                           32'd68255999, 32'd68256000, 32'd94694399, 32'd126230399,
                           32'd126230400, 32'd951782400, 32'd2147483648,
                           LastInRange, LastInRange + 1, 32'hFFFF_FFFF};
        foreach (directed_words[i]) send_seconds(directed_words[i]);

        // Random words: mostly in range, with day edges and the range limit favored.
        for (int n = 0; n < RandomWords; n++) begin
            if (n == LongHoldAt) hold_request = 1'b1;
            if (n == RandomWords - QuietTail) quiet_tail = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: secs = $urandom_range(0, LastInRange);
                5:             secs = $urandom();
                6, 7: begin
                    day  = $urandom_range(0, LastDay);
                    secs = day * 86400 + ($urandom_range(0, 1) ? 86399 : 0);
                end
                8:             secs = LastInRange - 100 + $urandom_range(0, 200);
                default:       secs = $urandom_range(0, 200000);
            endcase
            send_seconds(secs);
        end
        s_valid <= 1'b0;

        // Drain the results still in flight, then allow for the block's latency.
        while (dates_pending != 0) @(negedge aclk);
        for (drain = 0; drain < DrainCycles; drain++) @(negedge aclk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #LimitNs;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
sv/esc_pkg.sv
sv/epoch_seconds_to_calendar.sv
test/calendar_checker.sv
test/tb.sv
